>>> hdl/tbaf_pkg.sv
// ----------------------------------------------------------------------------
// tbaf_pkg
// Shared types and constants of the thresholded box average filter: field
// widths, configuration register indexes, divider operand select and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package tbaf_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 11;
    localparam int WIN_W      = 6;
    localparam int THR_W      = 8;
    localparam int MAX_HEIGHT = 1024;
    localparam int AVG_MAX    = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_WINDOW    = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_ROW = 2'd0,
        DIV_COL = 2'd1,
        DIV_SUM = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_slot;
        logic     cap_ring;
        logic     mem_rd;
        logic     upd;
        logic     cap_avg;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic win_done;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/tbaf_div.sv
// ----------------------------------------------------------------------------
// tbaf_div
// Restoring divider, one quotient bit per cycle. Shared by the line slot,
// column ring and window average computations.
// ----------------------------------------------------------------------------
module tbaf_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder,
    output logic             o_done
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

>>> hdl/tbaf_ctrl.sv
// ----------------------------------------------------------------------------
// tbaf_ctrl
// Per-pixel sequencer: slot and ring modulo, memory read, sum update,
// optional average divide, result hand-off.
// ----------------------------------------------------------------------------
module tbaf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tbaf_pkg::t_sts i_sts,
    output tbaf_pkg::t_cmd o_cmd
);
    import tbaf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RSTART = 9'b000000010,
        S_RWAIT  = 9'b000000100,
        S_CWAIT  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_UPD    = 9'b000100000,
        S_ASTART = 9'b001000000,
        S_AWAIT  = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_ROW;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RSTART;
                end
            end
            S_RSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ROW;
                n_state         = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_slot  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_COL;
                    n_state         = S_CWAIT;
                end
            end
            S_CWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_ring = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.win_done ? S_ASTART : S_FIN;
            end
            S_ASTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SUM;
                n_state         = S_AWAIT;
            end
            S_AWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_avg = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

>>> hdl/tbaf_dp.sv
// ----------------------------------------------------------------------------
// tbaf_dp
// Datapath: configuration registers, frame position, line store, column
// sums, column-total ring, window sum, divider and output register.
// ----------------------------------------------------------------------------
module tbaf_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [tbaf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tbaf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [tbaf_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_frame_start,
    input  tbaf_pkg::t_cmd                   i_cmd,
    output tbaf_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_valid,
    output logic                             o_window_done,
    output logic                             o_write_enable,
    output logic [tbaf_pkg::POS_W-1:0]       o_center_row,
    output logic [tbaf_pkg::POS_W-1:0]       o_center_col,
    output logic [tbaf_pkg::PIX_W-1:0]       o_average
);
    import tbaf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WCW   = (WW > WIDTH_W) ? WW : WIDTH_W;
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW - 1) : 1;
    localparam int RW    = $clog2(MAX_WINDOW);
    localparam int COL_W = $clog2(MAX_WINDOW * 255 + 1);
    localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int D_W   = $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int XW    = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam int DVD_W = (SUM_W > XW) ? SUM_W : XW;
    localparam int DVS_W = (D_W > NW) ? D_W : NW;
    localparam int LD    = (MAX_WINDOW - 1) * (1 << CW);
    localparam int THD_W = THR_W + D_W;
    localparam int CMP_W = (THD_W > SUM_W) ? THD_W : SUM_W;

    // configuration
    logic [WIDTH_W-1:0]  r_cfg_w;
    logic [HEIGHT_W-1:0] r_cfg_h;
    logic [WIN_W-1:0]    r_cfg_n;
    logic [THR_W-1:0]    r_cfg_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= WIDTH_W'(1024);
            r_cfg_h   <= HEIGHT_W'(1024);
            r_cfg_n   <= WIN_W'(30);
            r_cfg_thr <= THR_W'(20);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:     r_cfg_w   <= i_cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:    r_cfg_h   <= i_cfg_data[HEIGHT_W-1:0];
                CFG_WINDOW:    r_cfg_n   <= i_cfg_data[WIN_W-1:0];
                CFG_THRESHOLD: r_cfg_thr <= i_cfg_data[THR_W-1:0];
                default:       r_cfg_thr <= r_cfg_thr;
            endcase
        end
    end

    // clamped geometry
    logic [WCW-1:0]      w_ext;
    logic [WCW-1:0]      w_cl;
    logic [HEIGHT_W-1:0] h_cl;
    logic [7:0]          n_ext;
    logic [NW-1:0]       n_cl;
    logic [2*NW-1:0]     n_sq;

    always_comb begin
        w_ext = WCW'(r_cfg_w);
        if (w_ext == '0) begin
            w_cl = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_cl = WCW'(MAX_WIDTH);
        end else begin
            w_cl = w_ext;
        end
        if (r_cfg_h == '0) begin
            h_cl = HEIGHT_W'(1);
        end else if (r_cfg_h > HEIGHT_W'(MAX_HEIGHT)) begin
            h_cl = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_cl = r_cfg_h;
        end
        n_ext = 8'(r_cfg_n);
        if (n_ext < 8'd2) begin
            n_cl = NW'(2);
        end else if (n_ext > 8'(MAX_WINDOW)) begin
            n_cl = NW'(MAX_WINDOW);
        end else begin
            n_cl = n_ext[NW-1:0];
        end
        n_sq = (2*NW)'(n_cl) * (2*NW)'(n_cl);
    end

    // position and item registers
    logic [POS_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [PIX_W-1:0] r_pix;
    logic [NW-1:0]    r_n;
    logic [D_W-1:0]   r_d;
    logic [THD_W-1:0] r_thrd;
    logic [SW-1:0]    r_slot;
    logic [RW-1:0]    r_ring;

    logic [CW-1:0]       col0;
    logic [POS_W-1:0]    row0;
    logic [CW-1:0]       col1;
    logic [HEIGHT_W-1:0] row1;
    logic [WCW-1:0]      c_inc;
    logic [HEIGHT_W-1:0] r_inc;

    always_comb begin
        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        if (WCW'(col0) >= w_cl) begin
            col1 = '0;
            row1 = HEIGHT_W'(row0) + HEIGHT_W'(1);
        end else begin
            col1 = col0;
            row1 = HEIGHT_W'(row0);
        end
        if (row1 >= h_cl) begin
            row1 = '0;
        end
        c_inc = WCW'(r_col) + WCW'(1);
        r_inc = HEIGHT_W'(r_row) + HEIGHT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.accept) begin
            r_row <= row1[POS_W-1:0];
            r_col <= col1;
        end else if (i_cmd.fin) begin
            // advance to the next raster position
            if (c_inc >= w_cl) begin
                r_col <= '0;
                r_row <= (r_inc >= h_cl) ? '0 : r_inc[POS_W-1:0];
            end else begin
                r_col <= c_inc[CW-1:0];
            end
        end
    end

    // divider
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;
    logic             div_done;
    logic [SUM_W-1:0] r_wsum;

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_ROW: begin
                div_dvd = DVD_W'(r_row);
                div_dvs = DVS_W'(r_n) - DVS_W'(1);
            end
            DIV_COL: begin
                div_dvd = DVD_W'(r_col);
                div_dvs = DVS_W'(r_n);
            end
            DIV_SUM: begin
                div_dvd = DVD_W'(r_wsum);
                div_dvs = DVS_W'(r_d);
            end
            default: begin
                div_dvd = '0;
                div_dvs = '1;
            end
        endcase
    end

    tbaf_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel;
            r_n   <= n_cl;
            r_d   <= D_W'(n_sq - (2*NW)'(1));
        end
        if (i_cmd.cap_slot) begin
            r_slot <= div_rem[SW-1:0];
        end
        if (i_cmd.cap_ring) begin
            r_ring <= div_rem[RW-1:0];
        end
        if (i_cmd.mem_rd) begin
            r_thrd <= THD_W'(r_cfg_thr) * THD_W'(r_d);
        end
    end

    // memories
    logic [PIX_W-1:0] mem_line [LD];
    logic [COL_W-1:0] mem_col  [MAX_WIDTH];
    logic [COL_W-1:0] mem_ct   [MAX_WINDOW];
    logic [PIX_W-1:0] r_line_q;
    logic [COL_W-1:0] r_col_q;
    logic [COL_W-1:0] r_ct_q;
    logic [SW+CW-1:0] line_addr;

    assign line_addr = {r_slot, r_col};

    logic [COL_W-1:0] total;
    logic [COL_W-1:0] col_new;
    logic [SUM_W-1:0] wsum_new;
    logic             row_full;
    logic             col_full;
    logic             col_ge_n;
    logic             win;

    always_comb begin
        row_full = XW'(r_row) >= (XW'(r_n) - XW'(1));
        col_full = XW'(r_col) >= (XW'(r_n) - XW'(1));
        col_ge_n = XW'(r_col) >= XW'(r_n);
        win      = row_full && col_full;
        if (r_row == '0) begin
            total   = COL_W'(r_pix);
            col_new = COL_W'(r_pix);
        end else begin
            total   = r_col_q + COL_W'(r_pix);
            col_new = total - (row_full ? COL_W'(r_line_q) : '0);
        end
        if (r_col == '0) begin
            wsum_new = SUM_W'(total);
        end else begin
            wsum_new = r_wsum + SUM_W'(total) - (col_ge_n ? SUM_W'(r_ct_q) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_line_q <= mem_line[line_addr];
        end
        if (i_cmd.upd) begin
            mem_line[line_addr] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_col_q <= mem_col[r_col];
        end
        if (i_cmd.upd) begin
            mem_col[r_col] <= col_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_ct_q <= mem_ct[r_ring];
        end
        if (i_cmd.upd) begin
            mem_ct[r_ring] <= total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
        end else if (i_cmd.upd) begin
            r_wsum <= wsum_new;
        end
    end

    // average and threshold
    logic [PIX_W-1:0] r_avg;
    logic             r_we;
    logic [XW-1:0]    crow_x;
    logic [XW-1:0]    ccol_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_avg) begin
            r_avg <= (div_quo > DVD_W'(AVG_MAX)) ? PIX_W'(AVG_MAX) : div_quo[PIX_W-1:0];
            r_we  <= CMP_W'(r_wsum) > CMP_W'(r_thrd);
        end
    end

    always_comb begin
        crow_x = XW'(r_row) + XW'(r_n >> 1) - XW'(r_n) + XW'(1);
        ccol_x = XW'(r_col) + XW'(r_n >> 1) - XW'(r_n) + XW'(1);
    end

    // output register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            o_window_done  <= win;
            o_write_enable <= win && r_we;
            o_center_row   <= win ? crow_x[POS_W-1:0] : '0;
            o_center_col   <= win ? ccol_x[POS_W-1:0] : '0;
            o_average      <= win ? r_avg : '0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sts.div_done = div_done;
    assign o_sts.win_done = win;
    assign o_sts.out_free = !r_ovalid || i_out_ready;

endmodule

>>> hdl/thresholded_box_average_filter_core.sv
// ----------------------------------------------------------------------------
// thresholded_box_average_filter_core
// Sliding square-window mean over a raster grey stream with a threshold test.
// ----------------------------------------------------------------------------
// One pixel word in gives one result word out. The core accepts no new pixel
// word until the last one has been handed to the output register, which
// waits while the sink stalls. The pace is set by the single bit-serial
// divider, which computes the line slot (row mod window_size-1), the column
// ring slot (column mod window_size) and, for a full window, the average.
// The line store is not cleared after reset; its lines are filled by the
// first rows of each frame before they are read. Write configuration only
// while idle.
// ----------------------------------------------------------------------------
module thresholded_box_average_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tbaf_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_start,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_window_done,
    output logic                            o_write_enable,
    output logic [tbaf_pkg::POS_W-1:0]      o_center_row,
    output logic [tbaf_pkg::POS_W-1:0]      o_center_col,
    output logic [tbaf_pkg::PIX_W-1:0]      o_average,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tbaf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tbaf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbaf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tbaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tbaf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel        (i_pixel),
        .i_frame_start  (i_frame_start),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_ready),
        .o_valid        (o_valid),
        .o_window_done  (o_window_done),
        .o_write_enable (o_write_enable),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_average      (o_average)
    );

endmodule

>>> hdl/tbaf_chk.sv
// ----------------------------------------------------------------------------
// tbaf_chk
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module tbaf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_window_done,
    input logic       o_write_enable,
    input logic [9:0] o_center_row,
    input logic [9:0] o_center_col,
    input logic [7:0] o_average
);

    // a stalled result word holds its average, write and window flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average)
            && $stable(o_write_enable) && $stable(o_window_done))
        else $error("result word changed while stalled");

    a_we_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_enable |-> o_window_done)
        else $error("write reported without a full window");

    a_no_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_window_done |-> o_average == 8'd0 && o_center_row == 10'd0
            && o_center_col == 10'd0)
        else $error("fields not cleared without a window");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second pixel taken while one is in work");

endmodule

bind thresholded_box_average_filter_core tbaf_chk u_tbaf_chk (.*);

>>> dv/thresholded_box_average_filter_core_tb.sv
// ----------------------------------------------------------------------------
// thresholded_box_average_filter_core_tb
// Streams pixel words through the filter core under random source gaps and
// sink stalls, across several geometry and threshold settings, and scores
// every result word against an in-bench model of the sliding window mean or
// against a typed expected word from the directed table.
module thresholded_box_average_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tbaf_pkg::*;

    localparam int LINE_W    = 1024;
    localparam int WIN_MAX   = 32;
    localparam int DRAIN_CYC = 100;

    typedef struct packed {
        logic             done;
        logic             we;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] avg;
    } win_res_t;

    typedef struct packed {
        logic                  is_cfg;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        logic [PIX_W-1:0]      pix;
        logic                  fs;
        logic                  typed;
        win_res_t              res;
    } dir_row_t;

    typedef struct {
        int w;
        int h;
        int n;
        int thr;
        int cnt;
        bit gaps;
        bit hold;
    } phase_t;

    localparam win_res_t NONE = '{1'b0, 1'b0, 10'd0, 10'd0, 8'd0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_window_done;
    logic                  o_write_enable;
    logic [POS_W-1:0]      o_center_row;
    logic [POS_W-1:0]      o_center_col;
    logic [PIX_W-1:0]      o_average;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    thresholded_box_average_filter_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window model state
    logic [7:0]  line_mem [WIN_MAX-1][LINE_W];
    int unsigned col_sum [LINE_W];
    int unsigned col_tot [WIN_MAX];
    int unsigned win_sum, row_pos, col_pos;
    int unsigned m_width = 1024, m_height = 1024, m_win = 30, m_thr = 20;

    win_res_t pend_q[$];
    int       errors = 0;
    bit       sink_hold = 0;
    bit       drv_typed = 0;
    win_res_t drv_res = NONE;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function win_res_t window_mean(logic [7:0] pix, logic fs);
        int unsigned w, h, n, r, c, slot, ring, total, d, q;
        win_res_t res;
        w = clampu(m_width, 1, LINE_W);
        h = clampu(m_height, 1, MAX_HEIGHT);
        n = clampu(m_win, 2, WIN_MAX);
        res = NONE;
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        slot = r % (n - 1);
        if (r == 0) begin
            total = pix;
            col_sum[c] = pix;
        end else begin
            total = col_sum[c] + pix;
            col_sum[c] = total - ((r >= n - 1) ? line_mem[slot][c] : 0);
        end
        line_mem[slot][c] = pix;
        ring = c % n;
        if (c == 0) win_sum = total;
        else win_sum = win_sum + total - ((c >= n) ? col_tot[ring] : 0);
        col_tot[ring] = total;
        if (r >= n - 1 && c >= n - 1) begin
            d = n * n - 1;
            q = win_sum / d;
            res.done = 1'b1;
            res.avg  = (q > AVG_MAX) ? 8'(AVG_MAX) : q[7:0];
            res.we   = (longint'(win_sum) > longint'(m_thr) * d);
            res.row  = POS_W'(r - (n - 1) + n / 2);
            res.col  = POS_W'(c - (n - 1) + n / 2);
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return res;
    endfunction

    // score result words first, then log accepted pixel and register words
    always @(posedge i_clk) begin
        win_res_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pend_q.size() == 0) begin
                    $display("%0t: unexpected result word", $time);
                    errors++;
                end else begin
                    want = pend_q.pop_front();
                    if (o_window_done !== want.done) begin
                        $display("%0t: window_done exp %0d got %0d", $time, want.done,
                                 o_window_done);
                        errors++;
                    end
                    if (o_write_enable !== want.we) begin
                        $display("%0t: write_enable exp %0d got %0d", $time, want.we,
                                 o_write_enable);
                        errors++;
                    end
                    if (o_center_row !== want.row) begin
                        $display("%0t: center_row exp %0d got %0d", $time, want.row,
                                 o_center_row);
                        errors++;
                    end
                    if (o_center_col !== want.col) begin
                        $display("%0t: center_col exp %0d got %0d", $time, want.col,
                                 o_center_col);
                        errors++;
                    end
                    if (o_average !== want.avg) begin
                        $display("%0t: average exp %0d got %0d", $time, want.avg, o_average);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                want = window_mean(i_pixel, i_frame_start);
                pend_q.push_back(drv_typed ? drv_res : want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH:     m_width  = i_cfg_data;
                    CFG_HEIGHT:    m_height = i_cfg_data;
                    CFG_WINDOW:    m_win    = i_cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD: m_thr    = i_cfg_data[THR_W-1:0];
                endcase
            end
        end
    end

    // sink: random stalls, plus one long hold-off on request
    initial begin
        int sel, len;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                i_ready = 1'b0;
                repeat (600) @(negedge i_clk);
                sink_hold = 0;
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    i_ready = 1'b1;
                    len = $urandom_range(1, 30);
                end else if (sel < 9) begin
                    i_ready = 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    i_ready = 1'b0;
                    len = $urandom_range(20, 120);
                end
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // all tasks enter and leave at a falling edge
    task automatic wait_idle();
        while (pend_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] pix, logic fs, bit gaps, bit typed, win_res_t res);
        int gap, sel;
        gap = 0;
        if (gaps) begin
            sel = $urandom_range(0, 9);
            if (sel >= 9) gap = $urandom_range(20, 100);
            else if (sel >= 5) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_pixel       = pix;
        i_frame_start = fs;
        drv_typed     = typed;
        drv_res       = res;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    dir_row_t dir_tab [0:22] = '{
        '{1'b0, CFG_WIDTH, 11'd0, 8'd255, 1'b1, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd0,   1'b0, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd170, 1'b0, 1'b1, NONE},
        '{1'b1, CFG_WIDTH,     11'd2,   8'd0, 1'b0, 1'b0, NONE},
        '{1'b1, CFG_HEIGHT,    11'd2,   8'd0, 1'b0, 1'b0, NONE},
        '{1'b1, CFG_WINDOW,    11'd2,   8'd0, 1'b0, 1'b0, NONE},
        '{1'b1, CFG_THRESHOLD, 11'd0,   8'd0, 1'b0, 1'b0, NONE},
        // full-scale window: average saturates
        '{1'b0, CFG_WIDTH, 11'd0, 8'd255, 1'b1, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd255, 1'b0, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd255, 1'b0, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd255, 1'b0, 1'b1, '{1'b1, 1'b1, 10'd1, 10'd1, 8'd255}},
        '{1'b1, CFG_THRESHOLD, 11'd255, 8'd0, 1'b0, 1'b0, NONE},
        // dark window under the top threshold
        '{1'b0, CFG_WIDTH, 11'd0, 8'd0, 1'b1, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd0, 1'b0, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd0, 1'b0, 1'b1, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 10'd1, 10'd1, 8'd0}},
        '{1'b1, CFG_THRESHOLD, 11'd113, 8'd0, 1'b0, 1'b0, NONE},
        // truncated average equals threshold; the exact quotient is just above it
        '{1'b0, CFG_WIDTH, 11'd0, 8'd85, 1'b1, 1'b0, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd85, 1'b0, 1'b0, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd85, 1'b0, 1'b0, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd85, 1'b0, 1'b0, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd86, 1'b1, 1'b0, NONE},
        '{1'b0, CFG_WIDTH, 11'd0, 8'd1,  1'b0, 1'b0, NONE}
    };

    phase_t phases [0:10] = '{
        '{8, 6, 3, 40, 150, 1, 0},
        '{5, 5, 2, 0, 100, 1, 1},
        '{16, 8, 4, 100, 140, 0, 0},
        '{7, 10, 5, 255, 80, 1, 0},
        '{0, 4, 2, 20, 15, 1, 0},
        '{2047, 2, 63, 7, 20, 1, 0},
        '{6, 0, 2, 9, 15, 1, 0},
        '{32, 3, 32, 50, 40, 1, 0},
        '{10, 4, 1, 128, 90, 1, 0},
        '{9, 7, 0, 60, 120, 1, 0},
        '{2, 1023, 2, 200, 60, 0, 0}
    };

    initial begin
        logic [7:0] pix;
        logic       fs;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                i_valid = 1'b0;
                wait_idle();
                write_reg(dir_tab[k].idx, dir_tab[k].val);
            end else begin
                send_pixel(dir_tab[k].pix, dir_tab[k].fs, 1'b1, dir_tab[k].typed,
                           dir_tab[k].res);
            end
        end

        foreach (phases[p]) begin
            i_valid = 1'b0;
            wait_idle();
            write_reg(CFG_WIDTH, phases[p].w);
            write_reg(CFG_HEIGHT, phases[p].h);
            write_reg(CFG_WINDOW, phases[p].n);
            write_reg(CFG_THRESHOLD, phases[p].thr);
            if (phases[p].hold) sink_hold = 1;
            for (int i = 0; i < phases[p].cnt; i++) begin
                // bias pixels toward the threshold so both outcomes occur
                case ($urandom_range(0, 3))
                    0: pix = 8'($urandom);
                    1: pix = 8'($urandom_range(0, 15));
                    2: pix = 8'($urandom_range(240, 255));
                    default: pix = 8'(clampu(phases[p].thr + $urandom_range(0, 20), 0, 255)
                                      - $urandom_range(0, 10));
                endcase
                // restart the frame after a register change; rarely mid-frame too
                fs = (i == 0) || ($urandom_range(0, 99) == 0);
                send_pixel(pix, fs, phases[p].gaps, 1'b0, NONE);
            end
        end
        i_valid = 1'b0;
        while (pend_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (pend_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("[thresholded_box_average_filter_core] OK");
        end else begin
            $display("[thresholded_box_average_filter_core] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[thresholded_box_average_filter_core] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/tbaf_pkg.sv
hdl/tbaf_div.sv
hdl/tbaf_ctrl.sv
hdl/tbaf_dp.sv
hdl/thresholded_box_average_filter_core.sv
hdl/tbaf_chk.sv
dv/thresholded_box_average_filter_core_tb.sv
